/* hdl/des_rks_pkg.sv */
`default_nettype none

package des_rks_pkg;

  localparam int unsigned KEY_W    = 64;
  localparam int unsigned CD_W     = 56;
  localparam int unsigned HALF_W   = 28;
  localparam int unsigned SUBKEY_W = 48;
  localparam int unsigned ROUND_W  = 5;
  localparam int unsigned NUM_ROUNDS = 16;

  // DES bit numbering: position 1 is the MSB of the source word
  localparam logic [6:0] PC1_SEL [CD_W] = '{
    7'd57, 7'd49, 7'd41, 7'd33, 7'd25, 7'd17, 7'd9,  7'd1,  7'd58, 7'd50, 7'd42, 7'd34,
    7'd26, 7'd18, 7'd10, 7'd2,  7'd59, 7'd51, 7'd43, 7'd35, 7'd27, 7'd19, 7'd11, 7'd3,
    7'd60, 7'd52, 7'd44, 7'd36, 7'd63, 7'd55, 7'd47, 7'd39, 7'd31, 7'd23, 7'd15, 7'd7,
    7'd62, 7'd54, 7'd46, 7'd38, 7'd30, 7'd22, 7'd14, 7'd6,  7'd61, 7'd53, 7'd45, 7'd37,
    7'd29, 7'd21, 7'd13, 7'd5,  7'd28, 7'd20, 7'd12, 7'd4
  };

  localparam logic [5:0] PC2_SEL [SUBKEY_W] = '{
    6'd14, 6'd17, 6'd11, 6'd24, 6'd1,  6'd5,  6'd3,  6'd28, 6'd15, 6'd6,  6'd21, 6'd10,
    6'd23, 6'd19, 6'd12, 6'd4,  6'd26, 6'd8,  6'd16, 6'd7,  6'd27, 6'd20, 6'd13, 6'd2,
    6'd41, 6'd52, 6'd31, 6'd37, 6'd47, 6'd55, 6'd30, 6'd40, 6'd51, 6'd45, 6'd33, 6'd48,
    6'd44, 6'd49, 6'd39, 6'd56, 6'd34, 6'd53, 6'd46, 6'd42, 6'd50, 6'd36, 6'd29, 6'd32
  };

  // single rotation in rounds 1, 2, 9 and 16, double rotation elsewhere
  localparam int unsigned ROUND_SHIFT [NUM_ROUNDS] = '{
    1, 1, 2, 2, 2, 2, 2, 2, 1, 2, 2, 2, 2, 2, 2, 1
  };

  typedef struct packed {
    logic [SUBKEY_W-1:0] round_key;
    logic [ROUND_W-1:0]  round_number;
    logic                last_round;
  } beat_t;

  function automatic logic [CD_W-1:0] pc1(input logic [KEY_W-1:0] key);
    logic [CD_W-1:0] res;
    res = '0;
    for (int i = 0; i < CD_W; i++) begin
      res[CD_W-1-i] = key[KEY_W - int'(PC1_SEL[i])];
    end
    return res;
  endfunction

  function automatic logic [SUBKEY_W-1:0] pc2(input logic [CD_W-1:0] cd);
    logic [SUBKEY_W-1:0] res;
    res = '0;
    for (int i = 0; i < SUBKEY_W; i++) begin
      res[SUBKEY_W-1-i] = cd[CD_W - int'(PC2_SEL[i])];
    end
    return res;
  endfunction

  // total left rotation applied to each half by the end of round r (0-based)
  function automatic int unsigned cum_shift(input int unsigned r);
    int unsigned sum;
    sum = 0;
    for (int unsigned i = 0; i <= r; i++) begin
      sum += ROUND_SHIFT[i];
    end
    return sum % HALF_W;
  endfunction

  function automatic logic [HALF_W-1:0] rot_half(input logic [HALF_W-1:0] v,
                                                 input int unsigned n);
    logic [2*HALF_W-1:0] dbl;
    dbl = {v, v} << n;
    return dbl[2*HALF_W-1:HALF_W];
  endfunction

  function automatic logic [CD_W-1:0] rot_cd(input logic [CD_W-1:0] cd,
                                             input int unsigned n);
    return {rot_half(cd[CD_W-1:HALF_W], n), rot_half(cd[HALF_W-1:0], n)};
  endfunction

endpackage

`default_nettype wire

/* hdl/des_rks_expand.sv */
`default_nettype none

module des_rks_expand (
  input  wire logic [des_rks_pkg::KEY_W-1:0] key,
  output des_rks_pkg::beat_t                 beats [des_rks_pkg::NUM_ROUNDS]
);

  logic [des_rks_pkg::CD_W-1:0] cd;

  assign cd = des_rks_pkg::pc1(key);

  // each round's rotation is a fixed rewiring of the PC1 output
  for (genvar r = 0; r < des_rks_pkg::NUM_ROUNDS; r++) begin : g_round
    assign beats[r].round_key    = des_rks_pkg::pc2(
                                     des_rks_pkg::rot_cd(cd, des_rks_pkg::cum_shift(r)));
    assign beats[r].round_number = des_rks_pkg::ROUND_W'(r + 1);
    assign beats[r].last_round   = (r == des_rks_pkg::NUM_ROUNDS - 1);
  end

endmodule

`default_nettype wire

/* hdl/des_rks_cell.sv */
`default_nettype none

module des_rks_cell (
  input  wire logic                clk,
  input  wire logic                rst_n,
  input  wire logic                load,
  input  wire logic                shift,
  input  wire des_rks_pkg::beat_t  load_beat,
  input  wire logic                next_valid,
  input  wire des_rks_pkg::beat_t  next_beat,
  output logic                     valid,
  output des_rks_pkg::beat_t       beat
);

  logic               valid_r, valid_nxt;
  des_rks_pkg::beat_t beat_r, beat_nxt;

  always_comb begin
    valid_nxt = valid_r;
    beat_nxt  = beat_r;
    if (load) begin
      valid_nxt = 1'b1;
      beat_nxt  = load_beat;
    end else if (shift) begin
      // take the neighbor's beat, one step closer to the output
      valid_nxt = next_valid;
      beat_nxt  = next_beat;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else begin
      valid_r <= valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    beat_r <= beat_nxt;
  end

  assign valid = valid_r;
  assign beat  = beat_r;

endmodule

`default_nettype wire

/* hdl/des_round_key_schedule.sv */
// DES key schedule: each accepted 64-bit key (DES bit 1 = MSB) yields sixteen 48-bit round
// keys in round order, tagged with the round number 1..16, the sixteenth marked by
// out_last_round. All sixteen subkeys are formed in the cycle the key is taken and loaded
// into a row of sixteen cells that shifts one beat per cycle toward the output whenever
// the output beat is taken; cell 0 is the output register. A key therefore occupies the
// block for sixteen output beats, and the next key is taken in the same cycle the last
// beat of the previous one leaves, so with out_ready held high successive keys' beats
// follow with no gap. The first subkey appears in the cycle after the key is accepted.
`default_nettype none

module des_round_key_schedule (
  input  wire logic                             clk,
  input  wire logic                             rst_n,
  input  wire logic                             in_valid,
  output logic                                  in_ready,
  input  wire logic [des_rks_pkg::KEY_W-1:0]    in_key,
  output logic                                  out_valid,
  input  wire logic                             out_ready,
  output logic [des_rks_pkg::SUBKEY_W-1:0]      out_round_key,
  output logic [des_rks_pkg::ROUND_W-1:0]       out_round_number,
  output logic                                  out_last_round
);

  localparam int unsigned N = des_rks_pkg::NUM_ROUNDS;

  des_rks_pkg::beat_t load_beats [N];
  des_rks_pkg::beat_t cell_beat  [N];
  logic [N-1:0]       cell_valid;
  logic               in_fire;
  logic               out_fire;

  des_rks_expand u_expand (
    .key   (in_key),
    .beats (load_beats)
  );

  assign out_valid = cell_valid[0];
  assign out_fire  = out_valid && out_ready;
  // take a new key when no cell is occupied, or only the head cell is and it leaves now
  assign in_ready  = (cell_valid[N-1:1] == '0) && (!cell_valid[0] || out_ready);
  assign in_fire   = in_valid && in_ready;

  for (genvar i = 0; i < N; i++) begin : g_cell
    logic               nb_valid;
    des_rks_pkg::beat_t nb_beat;

    if (i == N - 1) begin : g_tail
      assign nb_valid = 1'b0;
      assign nb_beat  = '0;
    end else begin : g_mid
      assign nb_valid = cell_valid[i+1];
      assign nb_beat  = cell_beat[i+1];
    end

    des_rks_cell u_cell (
      .clk        (clk),
      .rst_n      (rst_n),
      .load       (in_fire),
      .shift      (out_fire),
      .load_beat  (load_beats[i]),
      .next_valid (nb_valid),
      .next_beat  (nb_beat),
      .valid      (cell_valid[i]),
      .beat       (cell_beat[i])
    );
  end

  assign out_round_key    = cell_beat[0].round_key;
  assign out_round_number = cell_beat[0].round_number;
  assign out_last_round   = cell_beat[0].last_round;

  // occupied cells always form a contiguous run starting at the head
  a_contiguous: assert property (@(posedge clk) disable iff (!rst_n)
    ((cell_valid >> 1) & ~cell_valid) == '0)
    else $error("gap in cell chain");

  a_load_full: assert property (@(posedge clk) disable iff (!rst_n)
    in_fire |=> (&cell_valid))
    else $error("key load did not fill every cell");

  a_more_follow: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && !out_last_round) |-> cell_valid[1])
    else $error("non-final subkey without successor");

  a_last_alone: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_last_round) |-> (cell_valid[N-1:1] == '0))
    else $error("final subkey with cells still occupied");

  a_round_step: assert property (@(posedge clk) disable iff (!rst_n)
    (out_fire && !out_last_round) |=>
      (out_valid && out_round_number == $past(out_round_number) + 5'd1))
    else $error("round number did not advance by one");

endmodule

`default_nettype wire
